// ===== rtl/mrpt_pkg.sv =====
`default_nettype none
package mrpt_pkg;
	typedef enum logic [3:0] {
		K_APPEND = 4'd0, K_FIND_NEXT = 4'd1, K_FIND_PAIR = 4'd2, K_DISJOINT = 4'd3,
		K_FIND_LAST = 4'd4, K_DEL_NEXT = 4'd5, K_CLEAR = 4'd6, K_DEL_LONGEST = 4'd7,
		K_PURGE = 4'd8, K_FIRST = 4'd9, K_MIN_HOP = 4'd10
	} kind_t;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [15:0] HOP_CEIL = 16'hffff;

	typedef struct packed {
		logic [31:0] next_hop;
		logic [31:0] last_hop;
		logic [15:0] hops;
		logic [31:0] expiry;
		logic [15:0] fwd_trust;
		logic [15:0] rev_trust;
	} path_t;
endpackage
`default_nettype wire

// ===== rtl/mrpt_scan.sv =====
`default_nettype none
// shared compare unit: judges one slot per cycle against the item
module mrpt_scan
	import mrpt_pkg::*;
(
	input  wire logic [3:0]  kind,
	input  wire path_t       slot,
	input  wire logic [31:0] next_hop,
	input  wire logic [31:0] last_hop,
	input  wire logic [31:0] now_tick,
	input  wire logic [15:0] best,
	output logic             match,
	output logic             better,
	output logic             expired
);
	always_comb begin
		match = 1'b0;
		case (kind)
			K_FIND_NEXT, K_DEL_NEXT: match = slot.next_hop == next_hop;
			K_FIND_PAIR: match = slot.next_hop == next_hop && slot.last_hop == last_hop;
			K_DISJOINT:  match = slot.next_hop == next_hop || slot.last_hop == last_hop;
			K_FIND_LAST: match = slot.last_hop == last_hop;
			default:     match = 1'b0;
		endcase
		better = (kind == K_DEL_LONGEST) ? (slot.hops > best) : (slot.hops < best);
		expired = slot.expiry < now_tick;
	end
endmodule
`default_nettype wire

// ===== rtl/multipath_route_path_table.sv =====
`default_nettype none
// Path table for one destination, up to MAX_PATHS entries kept packed in insertion order.
// One compare unit walks one slot per cycle, and that sets the time an item takes. A search
// ends at the first match or after the last held entry. A removal then shifts the later
// entries up, slot by slot from the removed one to the end. Purge rescans the same slot
// after each removal. Every item ends with a summary walk over the held entries (counted
// after the item), then the result register is loaded. Append, clear, first and unused kinds
// go straight to the summary walk. in_ready is low while an item is worked.
// A finished result waits in its own register, so the next item can be accepted and worked
// meanwhile; that item then holds in its output state until the earlier result is taken.
module multipath_route_path_table
	import mrpt_pkg::*;
#(
	parameter int MAX_PATHS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  kind,
	input  wire logic [31:0] next_hop,
	input  wire logic [31:0] last_hop,
	input  wire logic [15:0] hop_count,
	input  wire logic [31:0] expire_tick,
	input  wire logic [31:0] now_tick,
	input  wire logic [15:0] fwd_trust,
	input  wire logic [15:0] rev_trust,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [31:0]      hit_next_hop,
	output logic [31:0]      hit_last_hop,
	output logic [15:0]      hit_hop_count,
	output logic [31:0]      hit_expire,
	output logic [15:0]      hit_fwd_trust,
	output logic [15:0]      hit_rev_trust,
	output logic [3:0]       path_total,
	output logic [15:0]      least_hops,
	output logic [15:0]      most_hops,
	output logic [31:0]      latest_expiry
);
	localparam int IW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
	localparam int CW = $clog2(MAX_PATHS + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_SUM, S_OUT} state_t;

	state_t       state_q;
	path_t        mem_q [MAX_PATHS];
	logic [CW-1:0] held_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] sel_q;
	logic         found_q;
	logic [15:0]  best_q;
	logic [15:0]  inf_q;
	logic [3:0]   kind_q;
	logic [31:0]  nh_q, lh_q, now_q;
	logic [1:0]   st_q;
	path_t        hit_q;
	logic [15:0]  lo_q, hi_q;
	logic [31:0]  late_q;
	path_t        res_hit_q;
	logic [3:0]   res_total_q;
	logic [15:0]  res_lo_q, res_hi_q;
	logic [31:0]  res_late_q;
	logic         cur_match, cur_better, cur_expired;
	path_t        cur;
	path_t        nxt;
	logic [IW-1:0] ia;

	assign ia = idx_q[IW-1:0];
	assign cur = mem_q[ia];
	assign nxt = (ia == IW'(MAX_PATHS - 1)) ? cur : mem_q[ia + IW'(1)];

	mrpt_scan u_scan (
		.kind(kind_q), .slot(cur), .next_hop(nh_q), .last_hop(lh_q),
		.now_tick(now_q), .best(best_q),
		.match(cur_match), .better(cur_better), .expired(cur_expired)
	);

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready && kind == K_APPEND
			&& held_q < CW'(MAX_PATHS)) begin
			mem_q[held_q[IW-1:0]] <= '{next_hop, last_hop, hop_count, expire_tick,
				fwd_trust, rev_trust};
		end else if (state_q == S_SHIFT && idx_q + CW'(1) < held_q) begin
			mem_q[ia] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q <= '0;
			idx_q <= '0;
			sel_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			inf_q <= 16'd255;
			kind_q <= '0;
			nh_q <= '0;
			lh_q <= '0;
			now_q <= '0;
			st_q <= ST_MISS;
			hit_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			late_q <= '0;
			res_hit_q <= '0;
			res_total_q <= '0;
			res_lo_q <= '0;
			res_hi_q <= '0;
			res_late_q <= '0;
			out_valid <= 1'b0;
			status <= ST_MISS;
		end else begin
			if (cfg_we) inf_q <= cfg_wdata;
			if (state_q == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						kind_q <= kind;
						nh_q <= next_hop;
						lh_q <= last_hop;
						now_q <= now_tick;
						idx_q <= '0;
						found_q <= 1'b0;
						hit_q <= '0;
						st_q <= ST_MISS;
						best_q <= (kind == K_DEL_LONGEST) ? 16'd0 : HOP_CEIL;
						state_q <= S_SCAN;
						case (kind)
							K_APPEND: begin
								if (held_q < CW'(MAX_PATHS)) begin
									held_q <= held_q + CW'(1);
									hit_q <= '{next_hop, last_hop, hop_count, expire_tick,
										fwd_trust, rev_trust};
									st_q <= ST_OK;
								end else begin
									st_q <= ST_FULL;
								end
								state_q <= S_SUM;
							end
							K_CLEAR: begin
								held_q <= '0;
								st_q <= ST_OK;
								state_q <= S_SUM;
							end
							K_PURGE: st_q <= ST_OK;
							K_FIRST: begin
								if (held_q != '0) begin
									hit_q <= mem_q[0];
									st_q <= ST_OK;
								end
								state_q <= S_SUM;
							end
							K_FIND_NEXT, K_FIND_PAIR, K_DISJOINT, K_FIND_LAST, K_DEL_NEXT,
							K_DEL_LONGEST, K_MIN_HOP: ;
							default: state_q <= S_SUM;
						endcase
						if (kind == K_DISJOINT) st_q <= ST_OK;
					end
				end
				S_SCAN: begin
					if (idx_q >= held_q) begin
						if (found_q && (kind_q == K_DEL_NEXT || kind_q == K_DEL_LONGEST)) begin
							idx_q <= CW'(sel_q);
							state_q <= S_SHIFT;
						end else begin
							idx_q <= '0;
							state_q <= S_SUM;
						end
					end else begin
						case (kind_q)
							K_PURGE: begin
								if (cur_expired) state_q <= S_SHIFT;
								else idx_q <= idx_q + CW'(1);
								sel_q <= ia;
							end
							K_DEL_LONGEST, K_MIN_HOP: begin
								if (cur_better) begin
									best_q <= cur.hops;
									sel_q <= ia;
									found_q <= 1'b1;
									hit_q <= cur;
									st_q <= ST_OK;
								end
								idx_q <= idx_q + CW'(1);
							end
							default: begin
								if (cur_match) begin
									found_q <= 1'b1;
									sel_q <= ia;
									hit_q <= cur;
									st_q <= (kind_q == K_DISJOINT) ? ST_MISS : ST_OK;
									idx_q <= held_q;
								end else begin
									idx_q <= idx_q + CW'(1);
								end
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (idx_q + CW'(1) < held_q) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						held_q <= held_q - CW'(1);
						if (kind_q == K_PURGE) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_SUM;
						end
						idx_q <= (kind_q == K_PURGE) ? CW'(sel_q) : '0;
					end
				end
				S_SUM: begin
					// summary walk, one slot per cycle
					if (idx_q == '0) begin
						lo_q <= inf_q;
						hi_q <= '0;
						late_q <= '0;
						if (held_q == '0) state_q <= S_OUT;
						else idx_q <= idx_q + CW'(1);
					end else begin
						if (mem_q[IW'(idx_q - CW'(1))].hops < lo_q)
							lo_q <= mem_q[IW'(idx_q - CW'(1))].hops;
						if (mem_q[IW'(idx_q - CW'(1))].hops > hi_q)
							hi_q <= mem_q[IW'(idx_q - CW'(1))].hops;
						if (mem_q[IW'(idx_q - CW'(1))].expiry > late_q)
							late_q <= mem_q[IW'(idx_q - CW'(1))].expiry;
						if (idx_q == held_q) state_q <= S_OUT;
						else idx_q <= idx_q + CW'(1);
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						status <= st_q;
						res_hit_q <= hit_q;
						res_total_q <= 4'(held_q);
						res_lo_q <= lo_q;
						res_hi_q <= (hi_q == '0) ? inf_q : hi_q;
						res_late_q <= late_q;
						idx_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign hit_next_hop = res_hit_q.next_hop;
	assign hit_last_hop = res_hit_q.last_hop;
	assign hit_hop_count = res_hit_q.hops;
	assign hit_expire = res_hit_q.expiry;
	assign hit_fwd_trust = res_hit_q.fwd_trust;
	assign hit_rev_trust = res_hit_q.rev_trust;
	assign path_total = res_total_q;
	assign least_hops = res_lo_q;
	assign most_hops = res_hi_q;
	assign latest_expiry = res_late_q;
endmodule
`default_nettype wire

// ===== rtl/mrpt_checker.sv =====
`default_nettype none
module mrpt_checker
	import mrpt_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [3:0]  path_total
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(path_total)) else $error("result changed while held");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> path_total <= 4'd8) else $error("count");
endmodule

bind multipath_route_path_table mrpt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.path_total(path_total)
);
`default_nettype wire

// ===== dv/multipath_route_path_table_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module multipath_route_path_table_tb;
	import mrpt_pkg::*;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] next_hop;
		logic [31:0] last_hop;
		logic [15:0] hop_count;
		logic [31:0] expire_tick;
		logic [31:0] now_tick;
		logic [15:0] fwd_trust;
		logic [15:0] rev_trust;
	} op_t;

	typedef struct packed {
		logic [1:0]  status;
		path_t       hit;
		logic [3:0]  path_total;
		logic [15:0] least_hops;
		logic [15:0] most_hops;
		logic [31:0] latest_expiry;
	} reply_t;

	typedef struct {
		op_t    op;
		bit     typed;
		reply_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	op_t op_drv = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	reply_t got;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	bit hold_off = 1'b0;
	int errors = 0;
	int n_items = 0;
	int n_replies = 0;
	int kind_seen[16];

	// predictor state
	logic [15:0] sentinel = 16'd255;
	path_t paths[$];
	reply_t pending_replies[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("timeout at %0t", $time);
		$display("*** FAILED ***");
		$finish;
	end

	multipath_route_path_table u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(op_drv.kind), .next_hop(op_drv.next_hop), .last_hop(op_drv.last_hop),
		.hop_count(op_drv.hop_count), .expire_tick(op_drv.expire_tick),
		.now_tick(op_drv.now_tick), .fwd_trust(op_drv.fwd_trust),
		.rev_trust(op_drv.rev_trust),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(got.status), .hit_next_hop(got.hit.next_hop),
		.hit_last_hop(got.hit.last_hop), .hit_hop_count(got.hit.hops),
		.hit_expire(got.hit.expiry), .hit_fwd_trust(got.hit.fwd_trust),
		.hit_rev_trust(got.hit.rev_trust), .path_total(got.path_total),
		.least_hops(got.least_hops), .most_hops(got.most_hops),
		.latest_expiry(got.latest_expiry)
	);

	function automatic reply_t table_update(op_t op);
		reply_t r;
		path_t p;
		int sel;
		bit m;
		logic [15:0] best;
		r = '0;
		r.status = ST_MISS;
		sel = -1;
		case (op.kind)
			K_APPEND: begin
				if (paths.size() < 8) begin
					p.next_hop = op.next_hop;
					p.last_hop = op.last_hop;
					p.hops = op.hop_count;
					p.expiry = op.expire_tick;
					p.fwd_trust = op.fwd_trust;
					p.rev_trust = op.rev_trust;
					paths.push_back(p);
					r.hit = p;
					r.status = ST_OK;
				end else begin
					r.status = ST_FULL;
				end
			end
			K_FIND_NEXT, K_FIND_PAIR, K_DISJOINT, K_FIND_LAST, K_DEL_NEXT: begin
				foreach (paths[i]) begin
					case (op.kind)
						K_FIND_NEXT, K_DEL_NEXT: m = paths[i].next_hop == op.next_hop;
						K_FIND_PAIR: m = paths[i].next_hop == op.next_hop &&
							paths[i].last_hop == op.last_hop;
						K_DISJOINT: m = paths[i].next_hop == op.next_hop ||
							paths[i].last_hop == op.last_hop;
						default: m = paths[i].last_hop == op.last_hop;
					endcase
					if (m && sel < 0)
						sel = i;
				end
				if (op.kind == K_DISJOINT)
					r.status = (sel >= 0) ? ST_MISS : ST_OK;
				else if (sel >= 0)
					r.status = ST_OK;
				if (sel >= 0) begin
					r.hit = paths[sel];
					if (op.kind == K_DEL_NEXT)
						paths.delete(sel);
				end
			end
			K_CLEAR: begin
				paths.delete();
				r.status = ST_OK;
			end
			K_DEL_LONGEST: begin
				best = 0;
				foreach (paths[i])
					if (paths[i].hops > best) begin
						best = paths[i].hops;
						sel = i;
					end
				if (sel >= 0) begin
					r.status = ST_OK;
					r.hit = paths[sel];
					paths.delete(sel);
				end
			end
			K_PURGE: begin
				for (int i = paths.size() - 1; i >= 0; i--)
					if (paths[i].expiry < op.now_tick)
						paths.delete(i);
				r.status = ST_OK;
			end
			K_FIRST: begin
				if (paths.size() > 0) begin
					r.status = ST_OK;
					r.hit = paths[0];
				end
			end
			K_MIN_HOP: begin
				best = HOP_CEIL;
				foreach (paths[i])
					if (paths[i].hops < best) begin
						best = paths[i].hops;
						sel = i;
					end
				if (sel >= 0) begin
					r.status = ST_OK;
					r.hit = paths[sel];
				end
			end
			default: ;
		endcase
		r.least_hops = sentinel;
		r.most_hops = 0;
		r.latest_expiry = 0;
		foreach (paths[i]) begin
			if (paths[i].hops < r.least_hops)
				r.least_hops = paths[i].hops;
			if (paths[i].hops > r.most_hops)
				r.most_hops = paths[i].hops;
			if (paths[i].expiry > r.latest_expiry)
				r.latest_expiry = paths[i].expiry;
		end
		if (r.most_hops == 0)
			r.most_hops = sentinel;
		r.path_total = 4'(paths.size());
		return r;
	endfunction

	task automatic offer_item(op_t op);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op_drv <= op;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_replies.push_back(table_update(op));
		n_items++;
		kind_seen[op.kind]++;
		@(negedge clk);
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (pending_replies.size() > 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_sentinel(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sentinel = v;
	endtask

	always @(negedge clk)
		out_ready <= !hold_off &&
			!(receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct);

	always @(posedge clk) begin
		reply_t want;
		if (out_valid && out_ready) begin
			n_replies++;
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply %h", $time, got);
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				end
				if (got.hit !== want.hit) begin
					errors++;
					$display("%0t: hit exp %h got %h", $time, want.hit, got.hit);
				end
				if (got.path_total !== want.path_total) begin
					errors++;
					$display("%0t: path_total exp %0d got %0d", $time,
						want.path_total, got.path_total);
				end
				if (got.least_hops !== want.least_hops) begin
					errors++;
					$display("%0t: least_hops exp %0d got %0d", $time,
						want.least_hops, got.least_hops);
				end
				if (got.most_hops !== want.most_hops) begin
					errors++;
					$display("%0t: most_hops exp %0d got %0d", $time,
						want.most_hops, got.most_hops);
				end
				if (got.latest_expiry !== want.latest_expiry) begin
					errors++;
					$display("%0t: latest_expiry exp %h got %h", $time,
						want.latest_expiry, got.latest_expiry);
				end
			end
		end
	end

	function automatic op_t mk(logic [3:0] k, logic [31:0] nh, logic [31:0] lh,
		logic [15:0] hc, logic [31:0] ex, logic [31:0] now, logic [15:0] ft, logic [15:0] rt);
		op_t o;
		o.kind = k;
		o.next_hop = nh;
		o.last_hop = lh;
		o.hop_count = hc;
		o.expire_tick = ex;
		o.now_tick = now;
		o.fwd_trust = ft;
		o.rev_trust = rt;
		return o;
	endfunction

	// small address pool so that matches are frequent
	function automatic logic [31:0] addr();
		case ($urandom_range(3))
			0: return $urandom_range(3);
			1: return 32'hffff_fffc + $urandom_range(3);
			default: return $urandom();
		endcase
	endfunction

	function automatic op_t random_op();
		op_t o;
		int w;
		o = mk('0, addr(), addr(), '0, '0, '0, 16'($urandom()), 16'($urandom()));
		w = $urandom_range(99);
		if (w < 30) o.kind = K_APPEND;
		else if (w < 97) o.kind = 4'($urandom_range(1, 10));
		else o.kind = 4'($urandom_range(11, 15));
		if (o.kind == K_CLEAR && $urandom_range(3) != 0)
			o.kind = K_FIRST;
		case ($urandom_range(4))
			0: o.hop_count = 0;
			1: o.hop_count = HOP_CEIL;
			2: o.hop_count = 16'($urandom());
			default: o.hop_count = 16'($urandom_range(1, 300));
		endcase
		o.expire_tick = $urandom_range(3) == 0 ? $urandom() : $urandom_range(1000);
		o.now_tick = $urandom_range(3) == 0 ? $urandom() : $urandom_range(1000);
		return o;
	endfunction

	row_t dir_rows[$];

	task automatic add_row(op_t o, bit typed = 1'b0, reply_t w = '0);
		row_t r;
		r.op = o;
		r.typed = typed;
		r.want = w;
		dir_rows.push_back(r);
	endtask

	initial begin
		reply_t w;
		logic [15:0] sentinels[4];
		sentinels = '{16'd0, 16'hffff, 16'd255, 16'd100};

		// empty table after reset: lookups miss, disjoint is OK, summary shows the sentinel
		w = '0; w.status = ST_MISS; w.least_hops = 255; w.most_hops = 255;
		add_row(mk(K_FIRST, 0, 0, 0, 0, 0, 0, 0), 1'b1, w);
		add_row(mk(K_MIN_HOP, 0, 0, 0, 0, 0, 0, 0), 1'b1, w);
		add_row(mk(K_DEL_LONGEST, 0, 0, 0, 0, 0, 0, 0), 1'b1, w);
		add_row(mk(4'd15, '1, '1, '1, '1, '1, '1, '1), 1'b1, w);
		w.status = ST_OK;
		add_row(mk(K_DISJOINT, 5, 6, 0, 0, 0, 0, 0), 1'b1, w);
		// all-ones append
		w = '0; w.status = ST_OK; w.hit = '1; w.path_total = 1;
		w.least_hops = 255; w.most_hops = 16'hffff; w.latest_expiry = '1;
		add_row(mk(K_APPEND, '1, '1, '1, '1, 0, '1, '1), 1'b1, w);
		add_row(mk(K_APPEND, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk(K_APPEND, 1, 2, 7, 50, 0, 16'h8000, 16'h0001));
		add_row(mk(K_APPEND, 3, 2, 7, 60, 0, 1, 2));
		add_row(mk(K_APPEND, 1, 9, 3, 70, 0, 3, 4));
		add_row(mk(K_APPEND, 4, 4, 255, 80, 0, 5, 6));
		add_row(mk(K_APPEND, 5, 5, 0, 90, 0, 7, 8));
		add_row(mk(K_APPEND, 6, 6, 9, 100, 0, 9, 10));
		add_row(mk(K_APPEND, 7, 7, 1, 110, 0, 11, 12));
		add_row(mk(K_FIND_NEXT, 1, 0, 0, 0, 0, 0, 0));
		add_row(mk(K_FIND_PAIR, 1, 9, 0, 0, 0, 0, 0));
		add_row(mk(K_DISJOINT, 99, 2, 0, 0, 0, 0, 0));
		add_row(mk(K_FIND_LAST, 0, 2, 0, 0, 0, 0, 0));
		add_row(mk(K_MIN_HOP, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk(K_DEL_LONGEST, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk(K_DEL_NEXT, 1, 0, 0, 0, 0, 0, 0));
		add_row(mk(K_PURGE, 0, 0, 0, 0, 75, 0, 0));
		add_row(mk(K_FIRST, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk(K_CLEAR, 0, 0, 0, 0, 0, 0, 0));

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			offer_item(dir_rows[i].op);
			if (dir_rows[i].typed && pending_replies[$] !== dir_rows[i].want) begin
				errors++;
				$display("%0t: table row %0d exp %h predicted %h", $time, i,
					dir_rows[i].want, pending_replies[$]);
			end
		end
		drain_replies();

		for (int ph = 0; ph < 8; ph++) begin
			set_sentinel(sentinels[ph % 4]);
			case (ph % 4)
				0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
				1: begin sender_idle_pct = 50; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 50; end
				default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
			endcase
			if (ph == 4) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (300) @(negedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			repeat (90) offer_item(random_op());
			drain_replies();
		end

		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		drain_replies();
		$display("ran %0d items, %0d replies checked, %0d errors", n_items, n_replies, errors);
		$display("appends %0d, deletes %0d, purges %0d, clears %0d, unused kinds %0d",
			kind_seen[K_APPEND], kind_seen[K_DEL_NEXT] + kind_seen[K_DEL_LONGEST],
			kind_seen[K_PURGE], kind_seen[K_CLEAR],
			kind_seen[11] + kind_seen[12] + kind_seen[13] + kind_seen[14] + kind_seen[15]);
		if (errors == 0 && pending_replies.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/mrpt_pkg.sv
rtl/mrpt_scan.sv
rtl/multipath_route_path_table.sv
rtl/mrpt_checker.sv
dv/multipath_route_path_table_tb.sv
